>>> rtl/tapt_pkg.sv
// Shared constants, arctangent table and status type for the tilt angle peak tracker.
// Used by tapt_cordic, tapt_peak and tilt_angle_peak_tracker_core; no dependencies.
`timescale 1ns / 1ps

package tapt_pkg;

    localparam int SAMPLE_BITS       = 16;
    localparam int ANGLE_FRAC_BITS   = 7;
    localparam int CORDIC_ITERATIONS = 16;

    localparam int TABLE_LEN  = 24;
    localparam int ACC_FRAC   = 16;
    localparam int GUARD_BITS = 4;

    // vector: sample + guard bits + one for negation + growth headroom
    localparam int DW      = SAMPLE_BITS + GUARD_BITS + 4;
    // angle accumulator: 360 deg in Q16 plus signed margin
    localparam int AW      = ACC_FRAC + 11;
    localparam int ANGLE_W = 16;
    localparam int ITER_W  = $clog2(TABLE_LEN);
    localparam int N_ITER  = (CORDIC_ITERATIONS > TABLE_LEN) ? TABLE_LEN : CORDIC_ITERATIONS;
    localparam int SHIFT   = ACC_FRAC - ANGLE_FRAC_BITS;

    localparam logic signed [AW-1:0] HALF_TURN = AW'(180) <<< ACC_FRAC;
    localparam logic signed [AW-1:0] FULL_TURN = AW'(360) <<< ACC_FRAC;
    localparam logic signed [AW-1:0] ROUND_ADD = (SHIFT > 0) ? (AW'(1) <<< (SHIFT - 1)) : '0;

    // atan(2^-i) in degrees, Q16, rounded to nearest
    localparam logic signed [AW-1:0] ATAN_TAB [0:TABLE_LEN-1] = '{
        AW'(2949120), AW'(1740967), AW'(919879), AW'(466945),
        AW'(234379),  AW'(117304),  AW'(58666),  AW'(29335),
        AW'(14668),   AW'(7334),    AW'(3667),   AW'(1833),
        AW'(917),     AW'(458),     AW'(229),    AW'(115),
        AW'(57),      AW'(29),      AW'(14),     AW'(7),
        AW'(4),       AW'(2),       AW'(1),      AW'(0)
    };

    typedef struct packed {
        logic ready;   // unit idle, may start
        logic done;    // angle valid, waiting to be taken
    } cordic_stat_t;

endpackage

>>> rtl/tilt_angle_peak_tracker_core.sv
// Top level of the tilt angle peak tracker: stream ports, output register, assertions.
// Depends on tapt_pkg, tapt_cordic and tapt_peak.
//
//  channel | dir | tdata (low bit up)                         | tuser
//  s_      | in  | accel_x[15:0], accel_z[31:16] (signed)      | mode
//  m_      | out | tilt_angle[15:0], peak_rise[31:16]          | -
//
// An item is loaded, passes through 16 CORDIC iterations in the single shared
// add/sub stage, then waits to be handed to the output register.
// A sample of all zeros skips the iterations and goes straight to the hand-over.
// s_tready is high only while the CORDIC unit is idle; a result waiting in the
// output register does not block the next sample. Reset clears control and the
// reference/peak state.
`timescale 1ns / 1ps

module tilt_angle_peak_tracker_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // accel_x [15:0], accel_z [31:16]
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // tilt_angle [15:0], peak_rise [31:16]
);

    tapt_pkg::cordic_stat_t cor_stat;
    logic [tapt_pkg::ANGLE_W-1:0] angle, peak_next;
    logic mode_reg, start, take;
    logic m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    assign s_tready = cor_stat.ready;
    assign start    = s_tvalid && s_tready;
    // hand over when the output slot is free or draining this cycle
    assign take     = cor_stat.done && (!m_tvalid_reg || m_tready);

    tapt_cordic u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .sample_x (s_tdata[15:0]),
        .sample_z (s_tdata[31:16]),
        .take     (take),
        .stat     (cor_stat),
        .angle    (angle)
    );

    tapt_peak u_peak (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .update    (take),
        .mode      (mode_reg),
        .angle     (angle),
        .peak_next (peak_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (start) begin
            mode_reg <= s_tuser;
        end
        if (take) begin
            m_tdata_reg <= {peak_next, angle};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_ready_done_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cor_stat.ready && cor_stat.done))
        else $error("cordic ready and done together");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while unit busy");

    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cor_stat.done))
        else $error("output loaded without a finished angle");

    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] <= 16'd46080))
        else $error("tilt angle beyond full turn");
`endif

endmodule

>>> rtl/tapt_cordic.sv
// Iterative vectoring CORDIC: one add/sub stage reused once per cycle under a small sequencer.
// Depends on tapt_pkg for widths, the arctangent table and the status struct.
`timescale 1ns / 1ps

module tapt_cordic (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [tapt_pkg::SAMPLE_BITS-1:0] sample_x,
    input  logic signed [tapt_pkg::SAMPLE_BITS-1:0] sample_z,
    input  logic                                 take,
    output tapt_pkg::cordic_stat_t               stat,
    output logic [tapt_pkg::ANGLE_W-1:0]         angle
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [tapt_pkg::ITER_W-1:0] iter_reg, iter_next;
    logic signed [tapt_pkg::DW-1:0] vx_reg, vx_next, vy_reg, vy_next;
    logic signed [tapt_pkg::AW-1:0] acc_reg, acc_next;

    logic signed [tapt_pkg::DW-1:0] x_ext, z_ext, dx, dy;
    logic signed [tapt_pkg::AW-1:0] acc_clamp, acc_round;

    assign x_ext = tapt_pkg::DW'(sample_x) <<< tapt_pkg::GUARD_BITS;
    assign z_ext = tapt_pkg::DW'(sample_z) <<< tapt_pkg::GUARD_BITS;
    assign dx    = vy_reg >>> iter_reg;
    assign dy    = vx_reg >>> iter_reg;

    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        acc_next   = acc_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    iter_next = '0;
                    if (sample_x == '0 && sample_z == '0) begin
                        acc_next   = tapt_pkg::HALF_TURN;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_RUN;
                        if (!sample_z[tapt_pkg::SAMPLE_BITS-1]) begin
                            vx_next  = z_ext;
                            vy_next  = x_ext;
                            acc_next = tapt_pkg::HALF_TURN;
                        end else begin
                            // rotate into the right half plane
                            vx_next  = -z_ext;
                            vy_next  = -x_ext;
                            acc_next = sample_x[tapt_pkg::SAMPLE_BITS-1] ? '0
                                                                          : tapt_pkg::FULL_TURN;
                        end
                    end
                end
            end
            ST_RUN: begin
                if (!vy_reg[tapt_pkg::DW-1]) begin
                    vx_next  = vx_reg + dx;
                    vy_next  = vy_reg - dy;
                    acc_next = acc_reg + tapt_pkg::ATAN_TAB[iter_reg];
                end else begin
                    vx_next  = vx_reg - dx;
                    vy_next  = vy_reg + dy;
                    acc_next = acc_reg - tapt_pkg::ATAN_TAB[iter_reg];
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == tapt_pkg::ITER_W'(tapt_pkg::N_ITER - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        iter_reg <= iter_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        acc_reg  <= acc_next;
    end

    // clamp to one full turn, then round half up to the output resolution
    always_comb begin
        if (acc_reg < 0) begin
            acc_clamp = '0;
        end else if (acc_reg > tapt_pkg::FULL_TURN) begin
            acc_clamp = tapt_pkg::FULL_TURN;
        end else begin
            acc_clamp = acc_reg;
        end
        acc_round = (acc_clamp + tapt_pkg::ROUND_ADD) >>> tapt_pkg::SHIFT;
    end

    assign angle      = acc_round[tapt_pkg::ANGLE_W-1:0];
    assign stat.ready = (state_reg == ST_IDLE);
    assign stat.done  = (state_reg == ST_DONE);

endmodule

>>> rtl/tapt_peak.sv
// Reference angle and peak rise registers with their update compare.
// Depends on tapt_pkg for the angle width.
`timescale 1ns / 1ps

module tapt_peak (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          update,
    input  logic                          mode,
    input  logic [tapt_pkg::ANGLE_W-1:0]  angle,
    output logic [tapt_pkg::ANGLE_W-1:0]  peak_next
);

    logic [tapt_pkg::ANGLE_W-1:0] ref_reg, ref_next, peak_reg;
    logic signed [tapt_pkg::ANGLE_W:0] diff;

    assign diff = $signed({1'b0, angle}) - $signed({1'b0, ref_reg});

    always_comb begin
        ref_next  = ref_reg;
        peak_next = peak_reg;
        if (!mode) begin
            ref_next  = angle;
            peak_next = '0;
        end else if (diff > $signed({1'b0, peak_reg})) begin
            peak_next = diff[tapt_pkg::ANGLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg  <= '0;
            peak_reg <= '0;
        end else if (update) begin
            ref_reg  <= ref_next;
            peak_reg <= peak_next;
        end
    end

endmodule

>>> sim/tilt_angle_peak_tracker_core_tb.sv
// Self-checking testbench for tilt_angle_peak_tracker_core: CORDIC tilt angle and peak rise.
// Depends on tapt_pkg and the core RTL; carries its own bit-exact angle and peak predictor.
`timescale 1ns / 1ps

module tilt_angle_peak_tracker_core_tb;

    typedef enum logic {
        MODE_REFERENCE = 1'b0,
        MODE_MEASURE   = 1'b1
    } sample_mode_t;

    typedef struct {
        logic [15:0] angle;
        logic [15:0] peak;
    } tilt_result_t;

    localparam int     STEPS         = 16;
    localparam int     ROUND_SHIFT   = 9;    // Q16 degrees down to 1/128 degree
    localparam longint HALF_TURN_Q16 = 64'sd180 <<< 16;
    localparam longint FULL_TURN_Q16 = 64'sd360 <<< 16;
    localparam longint ATAN_DEG_Q16 [STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // accel_x [15:0], accel_z [31:16]
    logic        s_tuser;    // mode
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // tilt_angle [15:0], peak_rise [31:16]

    tilt_result_t expected_tilt_q[$];
    logic [15:0]  base_angle;
    logic [15:0]  peak_rise;
    int           error_count;
    int           idle_cycles;
    bit           send_idle_en;
    bit           recv_stall_en;
    bit           hold_off_req;

    tilt_angle_peak_tracker_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Vectoring CORDIC: atan2(x, z) + 180 degrees, clamped and rounded half up.
    function automatic logic [15:0] cordic_tilt(logic signed [15:0] ax, logic signed [15:0] az);
        longint vx, vy, acc, dx, dy;
        if (ax == 0 && az == 0) begin
            acc = HALF_TURN_Q16;
        end else begin
            if (az >= 0) begin
                vx  = longint'(az) * 16;
                vy  = longint'(ax) * 16;
                acc = HALF_TURN_Q16;
            end else begin
                vx  = -longint'(az) * 16;
                vy  = -longint'(ax) * 16;
                acc = (ax >= 0) ? FULL_TURN_Q16 : 64'sd0;
            end
            for (int i = 0; i < STEPS; i++) begin
                dx = vy >>> i;
                dy = vx >>> i;
                if (vy >= 0) begin
                    vx  += dx;
                    vy  -= dy;
                    acc += ATAN_DEG_Q16[i];
                end else begin
                    vx  -= dx;
                    vy  += dy;
                    acc -= ATAN_DEG_Q16[i];
                end
            end
        end
        if (acc < 0) acc = 0;
        if (acc > FULL_TURN_Q16) acc = FULL_TURN_Q16;
        acc = (acc + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        return acc[15:0];
    endfunction

    // Update reference/peak state and queue the result the block should return.
    task automatic predict_tilt(sample_mode_t mode, logic signed [15:0] ax,
                                logic signed [15:0] az);
        tilt_result_t res;
        int           diff;
        res.angle = cordic_tilt(ax, az);
        if (mode == MODE_REFERENCE) begin
            base_angle = res.angle;
            peak_rise  = '0;
        end else begin
            diff = int'(res.angle) - int'(base_angle);
            if (diff > int'(peak_rise)) peak_rise = diff[15:0];
        end
        res.peak = peak_rise;
        expected_tilt_q.push_back(res);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one sample; returns at the falling edge after the transaction.
    task automatic send_sample(sample_mode_t mode, logic signed [15:0] ax,
                               logic signed [15:0] az);
        int gap;
        gap = send_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {az, ax};
        s_tuser  = mode;
        do @(posedge aclk); while (!s_tready);
        predict_tilt(mode, ax, az);
        @(negedge aclk);
    endtask

    function automatic logic signed [15:0] pick_axis();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 16'($urandom);
        if (r < 80) return 16'($urandom_range(0, 128) - 64);
        case ($urandom_range(0, 4))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return -16'sd1;
            3: return 16'sd1;
            default: return 16'sd0;
        endcase
    endfunction

    task automatic test_directed();
        sample_mode_t      dir_mode [20] = '{
            MODE_MEASURE, MODE_MEASURE, MODE_MEASURE, MODE_MEASURE, MODE_MEASURE,
            MODE_REFERENCE, MODE_MEASURE, MODE_MEASURE, MODE_MEASURE, MODE_MEASURE,
            MODE_MEASURE, MODE_REFERENCE, MODE_MEASURE, MODE_MEASURE, MODE_REFERENCE,
            MODE_MEASURE, MODE_MEASURE, MODE_REFERENCE, MODE_MEASURE, MODE_MEASURE
        };
        logic signed [15:0] dir_x [20] = '{
            0, 0, 0, 100, -100, 32767, -32768, 32767, -32768, -1,
            1, 0, -1, 32767, -32768, 32767, 0, 0, 1, -32768
        };
        logic signed [15:0] dir_z [20] = '{
            0, -100, 100, 0, 0, 32767, -32768, -32768, 32767, -1,
            -1, -32768, 32767, 0, 0, 1, 0, 0, 1, -1
        };
        for (int i = 0; i < 20; i++) send_sample(dir_mode[i], dir_x[i], dir_z[i]);
    endtask

    // Mostly well-formed sessions (reference then measurements), some stray items.
    task automatic test_random_sessions(int n_items);
        int sent;
        int run_len;
        sent = 0;
        while (sent < n_items) begin
            send_idle_en  = ($urandom_range(0, 3) != 0);
            recv_stall_en = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
                send_sample(sample_mode_t'($urandom_range(0, 1)), pick_axis(), pick_axis());
                sent++;
            end else begin
                send_sample(MODE_REFERENCE, pick_axis(), pick_axis());
                run_len = $urandom_range(1, 12);
                repeat (run_len) send_sample(MODE_MEASURE, pick_axis(), pick_axis());
                sent += run_len + 1;
            end
        end
    endtask

    // Hold off the result side so the block fills and drops s_tready.
    task automatic test_backpressure();
        send_idle_en  = 1'b0;
        recv_stall_en = 1'b0;
        @(negedge aclk);
        hold_off_req = 1'b1;
        send_sample(MODE_REFERENCE, pick_axis(), pick_axis());
        repeat (24) send_sample(MODE_MEASURE, pick_axis(), pick_axis());
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int stall_left;
        bit hold_done;
        m_tready   = 1'b0;
        stall_left = 0;
        hold_done  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready  = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if (recv_stall_en && $urandom_range(0, 2) == 0) stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        tilt_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_tilt_q.size() == 0) begin
                $error("result with no sample pending: tdata %h", m_tdata);
                error_count++;
            end else begin
                exp_res = expected_tilt_q.pop_front();
                if (m_tdata[15:0] !== exp_res.angle) begin
                    $error("tilt_angle: expected %0d, got %0d", exp_res.angle, m_tdata[15:0]);
                    error_count++;
                end
                if (m_tdata[31:16] !== exp_res.peak) begin
                    $error("peak_rise: expected %0d, got %0d", exp_res.peak, m_tdata[31:16]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tilt_angle_peak_tracker_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = MODE_REFERENCE;
        base_angle    = '0;
        peak_rise     = '0;
        send_idle_en  = 1'b0;
        recv_stall_en = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_backpressure();
        test_random_sessions(1350);

        s_tvalid = 1'b0;
        while (expected_tilt_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("tilt_angle_peak_tracker_core_tb: done, clean");
        end else begin
            $display("tilt_angle_peak_tracker_core_tb: done, errors");
        end
        $finish;
    end

endmodule

>>> tilt_angle_peak_tracker_core.f
rtl/tapt_pkg.sv
rtl/tapt_cordic.sv
rtl/tapt_peak.sv
rtl/tilt_angle_peak_tracker_core.sv
sim/tilt_angle_peak_tracker_core_tb.sv
